// File: design/lksc_pkg.sv
`timescale 1ns / 1ps
package lksc_pkg;

  localparam int KeyW   = 32;
  localparam int SizeW  = 10;
  localparam int StampW = 64;
  localparam int SlotW  = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [SizeW-1:0]  size;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctrl_t;

endpackage

// File: design/lksc_if.sv
`timescale 1ns / 1ps
interface lksc_req_if;
  logic                        valid;
  logic                        ready;
  logic [lksc_pkg::KeyW-1:0]   font_key;
  logic [lksc_pkg::SizeW-1:0]  glyph_size;

  modport source (output valid, output font_key, output glyph_size, input ready);
  modport sink   (input valid, input font_key, input glyph_size, output ready);
endinterface

interface lksc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lksc_pkg::SlotW-1:0]  slot;
  logic                        hit;
  logic                        evicted;

  modport source (output valid, output slot, output hit, output evicted, input ready);
  modport sink   (input valid, input slot, input hit, input evicted, output ready);
endinterface

// File: design/lksc_ram.sv
`timescale 1ns / 1ps
module lksc_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lksc_scan.sv
`timescale 1ns / 1ps
module lksc_scan #(
  parameter int IdxW = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lksc_pkg::scan_ctrl_t        ctrl_i,
  input  logic [IdxW-1:0]             idx_i,
  input  lksc_pkg::entry_t            entry_i,
  input  logic [lksc_pkg::KeyW-1:0]   key_i,
  input  logic [lksc_pkg::SizeW-1:0]  size_i,
  output logic                        hit_o,
  output logic [IdxW-1:0]             hit_idx_o,
  output logic [IdxW-1:0]             min_idx_o
);

  logic                        hit_q, hit_d;
  logic [IdxW-1:0]             hit_idx_q, hit_idx_d;
  logic [IdxW-1:0]             min_idx_q, min_idx_d;
  logic [lksc_pkg::StampW-1:0] best_q, best_d;

  always_comb begin
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    min_idx_d = min_idx_q;
    best_d    = best_q;
    if (ctrl_i.clear) begin
      hit_d     = 1'b0;
      hit_idx_d = '0;
      min_idx_d = '0;
      best_d    = '1;
    end else if (ctrl_i.sample) begin
      if (entry_i.key == key_i && entry_i.size == size_i) begin
        hit_d     = 1'b1;
        hit_idx_d = idx_i;
      end
      if (entry_i.stamp < best_q) begin
        best_d    = entry_i.stamp;
        min_idx_d = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
      min_idx_q <= '0;
      best_q    <= '1;
    end else begin
      hit_q     <= hit_d;
      hit_idx_q <= hit_idx_d;
      min_idx_q <= min_idx_d;
      best_q    <= best_d;
    end
  end

  assign hit_o     = hit_q;
  assign hit_idx_o = hit_idx_q;
  assign min_idx_o = min_idx_q;

endmodule

// File: design/lru_keyed_slot_cache.sv
`timescale 1ns / 1ps
// Fully associative key/size cache with least-recently-used replacement. Each request
// transaction returns one response: the slot now holding the pair, a hit flag, and an
// evicted flag when a miss refilled the oldest slot. At most SLOTS-1 slots are ever
// used. Key, size and stamp of each slot sit in one RAM with a single read port that is
// swept one entry per cycle over the filled slots; an empty cache skips the sweep. A new
// request is taken while the previous response still waits in the output register. No
// clearing pass follows reset.
module lru_keyed_slot_cache #(
  parameter int SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lksc_req_if.sink    req_i,
  lksc_rsp_if.source  rsp_o
);

  localparam int IdxW = $clog2(SLOTS);
  localparam logic [IdxW-1:0] LastFill = IdxW'(SLOTS - 1);

  lksc_pkg::state_e             state_q, state_d;
  logic [IdxW-1:0]              fill_q, fill_d;
  logic [IdxW-1:0]              cnt_q, cnt_d;
  logic                         rd_pend_q;
  logic [IdxW-1:0]              rd_idx_q;
  logic [lksc_pkg::StampW-1:0]  use_q, use_d;
  logic [lksc_pkg::KeyW-1:0]    key_q;
  logic [lksc_pkg::SizeW-1:0]   size_q;

  logic                         out_valid_q, out_valid_d;
  logic [lksc_pkg::SlotW-1:0]   slot_q;
  logic                         hit_q;
  logic                         evicted_q;

  logic                         accept;
  logic                         rd_en;
  logic                         decide_go;
  lksc_pkg::scan_ctrl_t         scan_ctrl;
  lksc_pkg::entry_t             rd_entry;
  lksc_pkg::entry_t             wr_entry;

  logic                         scan_hit;
  logic [IdxW-1:0]              hit_idx;
  logic [IdxW-1:0]              min_idx;

  logic [IdxW-1:0]              dec_idx;
  logic                         dec_evict;
  logic                         dec_append;
  logic [IdxW+2:0]              slot_ext;
  logic [lksc_pkg::StampW-1:0]  stamp_new;

  lksc_ram #(
    .Width ($bits(lksc_pkg::entry_t)),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (decide_go),
    .waddr_i (dec_idx),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (cnt_q),
    .rdata_o (rd_entry)
  );

  lksc_scan #(
    .IdxW (IdxW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (scan_ctrl),
    .idx_i     (rd_idx_q),
    .entry_i   (rd_entry),
    .key_i     (key_q),
    .size_i    (size_q),
    .hit_o     (scan_hit),
    .hit_idx_o (hit_idx),
    .min_idx_o (min_idx)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      lksc_pkg::S_IDLE: begin
        if (req_i.valid) begin
          state_d = (fill_q == '0) ? lksc_pkg::S_DECIDE : lksc_pkg::S_SCAN;
        end
      end
      lksc_pkg::S_SCAN: begin
        if (cnt_q == fill_q - IdxW'(1)) begin
          state_d = lksc_pkg::S_DRAIN;
        end
      end
      lksc_pkg::S_DRAIN: begin
        state_d = lksc_pkg::S_DECIDE;
      end
      lksc_pkg::S_DECIDE: begin
        if (!out_valid_q || rsp_o.ready) begin
          state_d = lksc_pkg::S_IDLE;
        end
      end
      default: state_d = lksc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready      = 1'b0;
    rd_en            = 1'b0;
    decide_go        = 1'b0;
    case (state_q)
      lksc_pkg::S_IDLE:   req_i.ready = 1'b1;
      lksc_pkg::S_SCAN:   rd_en = 1'b1;
      lksc_pkg::S_DRAIN:  rd_en = 1'b0;
      lksc_pkg::S_DECIDE: decide_go = !out_valid_q || rsp_o.ready;
      default:            req_i.ready = 1'b0;
    endcase
  end

  assign accept           = req_i.valid && req_i.ready;
  assign scan_ctrl.clear  = accept;
  assign scan_ctrl.sample = rd_pend_q;

  always_comb begin
    dec_evict  = 1'b0;
    dec_append = 1'b0;
    if (scan_hit) begin
      dec_idx = hit_idx;
    end else if (fill_q == LastFill) begin
      dec_idx   = min_idx;
      dec_evict = 1'b1;
    end else begin
      dec_idx    = fill_q;
      dec_append = 1'b1;
    end
  end

  assign stamp_new      = use_q + lksc_pkg::StampW'(1);
  assign wr_entry.key   = key_q;
  assign wr_entry.size  = size_q;
  assign wr_entry.stamp = stamp_new;
  assign slot_ext       = {3'b000, dec_idx};

  always_comb begin
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    use_d       = use_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      cnt_d = '0;
    end else if (rd_en) begin
      cnt_d = cnt_q + IdxW'(1);
    end
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (decide_go) begin
      use_d       = stamp_new;
      out_valid_d = 1'b1;
      if (dec_append) begin
        fill_d = fill_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lksc_pkg::S_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      use_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_en;
      use_q       <= use_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (accept) begin
      key_q  <= req_i.font_key;
      size_q <= req_i.glyph_size;
    end
    if (decide_go) begin
      slot_q    <= slot_ext[lksc_pkg::SlotW-1:0];
      hit_q     <= scan_hit;
      evicted_q <= dec_evict;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.slot    = slot_q;
  assign rsp_o.hit     = hit_q;
  assign rsp_o.evicted = evicted_q;

endmodule

// File: design/lksc_checker.sv
`timescale 1ns / 1ps
module lksc_checker #(
  parameter int SLOTS = 8
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [lksc_pkg::SlotW-1:0] rsp_slot_i,
  input logic                       rsp_hit_i,
  input logic                       rsp_evicted_i
);

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_hit_i && rsp_evicted_i))
    else $error("hit and evicted both set");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && SLOTS <= 8) |-> (int'(rsp_slot_i) <= SLOTS - 2))
    else $error("slot beyond usable range");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken while previous one in flight");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_slot_i) && $stable(rsp_hit_i) && $stable(rsp_evicted_i)))
    else $error("stalled response changed");

endmodule

bind lru_keyed_slot_cache lksc_checker #(
  .SLOTS (SLOTS)
) u_lksc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_slot_i    (rsp_o.slot),
  .rsp_hit_i     (rsp_o.hit),
  .rsp_evicted_i (rsp_o.evicted)
);

// File: sim/lru_keyed_slot_cache_tb.sv
`timescale 1ns / 1ps
module lru_keyed_slot_cache_tb;

  localparam int KeyW       = lksc_pkg::KeyW;
  localparam int SizeW      = lksc_pkg::SizeW;
  localparam int SlotW      = lksc_pkg::SlotW;
  localparam int SLOTS      = 8;
  localparam int NumRandom  = 650;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = SLOTS + 6;
  localparam int LongHold   = 250;

  typedef struct {
    logic [KeyW-1:0]  key;
    logic [SizeW-1:0] size;
    bit               barrier;
  } lookup_req_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             hit;
    logic             evicted;
  } lookup_rsp_t;

  logic clk_i;
  logic rst_ni;

  lksc_req_if req_if ();
  lksc_rsp_if rsp_if ();

  lru_keyed_slot_cache #(
    .SLOTS(SLOTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  lookup_req_t pending_q[$];
  lookup_rsp_t slot_expect_q[$];

  int              filled_slots;
  logic [63:0]     access_count;
  logic [KeyW-1:0] tag_key[SLOTS];
  logic [SizeW-1:0] tag_size[SLOTS];
  logic [63:0]     tag_stamp[SLOTS];

  bit          req_taken;
  int          send_wait;
  int          recv_wait;
  int          hold_left;
  bit          hold_done;
  int          lookups_sent;
  int          lookups_done;
  int          hit_count;
  int          evict_count;
  int          errors;
  int          cycle_cnt;
  lookup_rsp_t want;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic lookup_rsp_t predict_lookup(input logic [KeyW-1:0] key,
                                                 input logic [SizeW-1:0] size);
    lookup_rsp_t r;
    int          idx;
    logic [63:0] oldest;
    idx       = 0;
    r.hit     = 1'b0;
    r.evicted = 1'b0;
    for (int i = 0; i < filled_slots; i++) begin
      if (tag_key[i] == key && tag_size[i] == size) begin
        idx   = i;
        r.hit = 1'b1;
      end
    end
    if (!r.hit) begin
      if (filled_slots + 1 >= SLOTS && filled_slots > 0) begin
        oldest = '1;
        idx    = 0;
        for (int i = 0; i < filled_slots; i++) begin
          if (tag_stamp[i] < oldest) begin
            oldest = tag_stamp[i];
            idx    = i;
          end
        end
        r.evicted = 1'b1;
      end else begin
        idx = filled_slots;
        filled_slots++;
      end
      tag_key[idx]  = key;
      tag_size[idx] = size;
    end
    access_count   = access_count + 64'd1;
    tag_stamp[idx] = access_count;
    r.slot         = idx[SlotW-1:0];
    return r;
  endfunction

  function automatic lookup_req_t make_lookup(input logic [KeyW-1:0] key,
                                              input logic [SizeW-1:0] size);
    lookup_req_t it;
    it.key     = key;
    it.size    = size;
    it.barrier = 1'b0;
    return it;
  endfunction

  function automatic lookup_req_t make_barrier();
    lookup_req_t it;
    it.key     = '0;
    it.size    = '0;
    it.barrier = 1'b1;
    return it;
  endfunction

  function automatic void queue_item(input lookup_req_t it);
    pending_q.insert(pending_q.size(), it);
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && !req_taken) begin
      end else if (send_wait > 0) begin
        req_if.valid <= 1'b0;
        send_wait--;
      end else if (pending_q.size() > 0 && pending_q[0].barrier) begin
        req_if.valid <= 1'b0;
        if (slot_expect_q.size() == 0) void'(pending_q.pop_front());
      end else if (pending_q.size() > 0) begin
        req_if.valid      <= 1'b1;
        req_if.font_key   <= pending_q[0].key;
        req_if.glyph_size <= pending_q[0].size;
        void'(pending_q.pop_front());
        lookups_sent++;
        send_wait = ((lookups_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 14);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response ready driver, with one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && lookups_done >= 60) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (recv_wait > 0) begin
        rsp_if.ready <= 1'b0;
        recv_wait--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (rsp_if.valid && rsp_if.ready) begin
        if (slot_expect_q.size() == 0) begin
          $display("%0t unexpected response: slot=%0d hit=%0b evicted=%0b", $time,
                   rsp_if.slot, rsp_if.hit, rsp_if.evicted);
          errors++;
        end else begin
          want = slot_expect_q.pop_front();
          if (rsp_if.slot !== want.slot) begin
            $display("%0t slot mismatch: expected %0d actual %0d", $time, want.slot,
                     rsp_if.slot);
            errors++;
          end
          if (rsp_if.hit !== want.hit) begin
            $display("%0t hit mismatch: expected %0b actual %0b", $time, want.hit,
                     rsp_if.hit);
            errors++;
          end
          if (rsp_if.evicted !== want.evicted) begin
            $display("%0t evicted mismatch: expected %0b actual %0b", $time, want.evicted,
                     rsp_if.evicted);
            errors++;
          end
          if (want.hit) hit_count++;
          if (want.evicted) evict_count++;
        end
        lookups_done++;
        recv_wait = ((lookups_done / 50) % 4 == 1) ? 0 : $urandom_range(0, 14);
      end
      req_taken = req_if.valid && req_if.ready;
      if (req_taken) begin
        slot_expect_q.insert(slot_expect_q.size(),
                             predict_lookup(req_if.font_key, req_if.glyph_size));
      end
      if (cycle_cnt >= CycleLimit) begin
        $display("%0t timeout: %0d lookups sent, %0d responses", $time, lookups_sent,
                 lookups_done);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [KeyW-1:0]  pool_key[12];
    logic [SizeW-1:0] pool_size[12];
    logic [KeyW-1:0]  k;
    logic [SizeW-1:0] s;
    int               pool_n;
    int               pick;
    int               bitpos;

    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.font_key   = '0;
    req_if.glyph_size = '0;
    rsp_if.ready      = 1'b0;
    filled_slots      = 0;
    access_count      = '0;
    req_taken         = 1'b0;
    send_wait         = 0;
    recv_wait         = 0;
    hold_left         = 0;
    hold_done         = 1'b0;
    lookups_sent      = 0;
    lookups_done      = 0;
    hit_count         = 0;
    evict_count       = 0;
    errors            = 0;
    cycle_cnt         = 0;
    pool_n            = 4;

    // empty store, hit, partial matches, fill to the limit, then evict and refresh
    queue_item(make_lookup(32'h0000_0000, 10'h000));
    queue_item(make_lookup(32'h0000_0000, 10'h000));
    queue_item(make_lookup(32'hFFFF_FFFF, 10'h3FF));
    queue_item(make_lookup(32'h0000_0000, 10'h3FF));
    queue_item(make_lookup(32'hFFFF_FFFF, 10'h000));
    queue_item(make_lookup(32'hFFFF_FFFF, 10'h3FF));
    queue_item(make_lookup(32'hA5A5_A5A5, 10'h155));
    queue_item(make_lookup(32'h5A5A_5A5A, 10'h2AA));
    queue_item(make_lookup(32'h0000_0001, 10'h001));
    queue_item(make_lookup(32'h8000_0000, 10'h200));
    queue_item(make_lookup(32'h0000_0000, 10'h000));
    queue_item(make_lookup(32'h0000_0000, 10'h3FF));
    queue_item(make_lookup(32'h0000_0001, 10'h001));
    queue_item(make_lookup(32'hFFFF_FFFF, 10'h000));
    queue_item(make_lookup(32'h8000_0000, 10'h200));
    queue_item(make_lookup(32'h8000_0000, 10'h201));
    queue_item(make_lookup(32'h8000_0001, 10'h200));
    queue_item(make_lookup(32'h0000_0001, 10'h001));
    queue_item(make_lookup(32'h7FFF_FFFF, 10'h1FF));
    queue_item(make_lookup(32'hA5A5_A5A5, 10'h155));
    queue_item(make_barrier());

    for (int i = 0; i < NumRandom; i++) begin
      if (i % 50 == 0) begin
        pool_n = $urandom_range(3, 12);
        for (int j = 0; j < 12; j++) begin
          pool_key[j]  = ($urandom_range(0, 3) == 0 && j > 0) ? pool_key[0] : $urandom;
          pool_size[j] = SizeW'($urandom_range(0, 1023));
        end
      end
      if (i == NumRandom / 2) queue_item(make_barrier());
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        bitpos = $urandom_range(0, pool_n - 1);
        k      = pool_key[bitpos];
        s      = pool_size[bitpos];
        if (pick >= 60) begin
          bitpos = $urandom_range(0, KeyW + SizeW - 1);
          if (bitpos < KeyW) k[bitpos] = ~k[bitpos];
          else s[bitpos-KeyW] = ~s[bitpos-KeyW];
        end
      end else if (pick < 85 && pending_q.size() > 0 && !pending_q[$].barrier) begin
        k = pending_q[$].key;
        s = pending_q[$].size;
      end else begin
        k = $urandom;
        s = SizeW'($urandom_range(0, 1023));
      end
      queue_item(make_lookup(k, s));
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (pending_q.size() != 0 || req_if.valid || slot_expect_q.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    if (slot_expect_q.size() != 0) begin
      $display("%0t %0d responses never arrived", $time, slot_expect_q.size());
      errors++;
    end
    $display("covered %0d lookups: %0d hits, %0d evictions, full-bit keys and sizes,",
             lookups_done, hit_count, evict_count);
    $display("long output stall with input backpressure, and two input drains");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
